>>> rtl/wsp_pkg.sv
package wsp_pkg;

    localparam int CLIP_W    = 52;
    localparam int PROD_W    = 64;
    localparam int DIM_W     = 15;
    localparam int DIV_STEPS = 33;
    localparam int FRAC_SH   = 15;
    localparam int OVF_SH    = DIV_STEPS - FRAC_SH;
    localparam int DOT_LAT   = 2;
    localparam int VIEW_LAT  = DIV_STEPS + 4;
    localparam int TOTAL_LAT = DOT_LAT + VIEW_LAT;

    localparam logic signed [CLIP_W-1:0] W_NEAR = CLIP_W'(6554);
    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);

    typedef enum logic [2:0] {
        CFG_ROW_X_LO,
        CFG_ROW_X_HI,
        CFG_ROW_Y_LO,
        CFG_ROW_Y_HI,
        CFG_ROW_W_LO,
        CFG_ROW_W_HI,
        CFG_WIDTH,
        CFG_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic        behind;
        logic [31:0] depth;
    } t_tag;

endpackage

>>> rtl/world_to_screen_projection.sv
// Projects one Q16.16 world point per beat to viewport pixels. Clip x, clip y and w come
// from three rows of the view matrix; screen x = W(cx+w)/(2w), screen y = H(w-cy)/(2w),
// truncated and saturated, both zero when w < 0.1 (behind flag set). Throughput is one
// point per clock while results are taken. A point passes the matrix multiply and sum,
// then the screen mapping: numerator, window scale, overflow check, a one-bit-per-stage
// divider and clamp. The whole pipeline stalls while a finished result is not taken.
// Users write registers via the cfg channel while no point is in flight; not enforced.
module world_to_screen_projection (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // world_x, world_y, world_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // screen_x, screen_y, depth_w
    output logic [0:0]   m_axis_tuser,   // behind_camera
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    localparam int CW  = wsp_pkg::CLIP_W;
    localparam int VL  = wsp_pkg::VIEW_LAT;
    localparam int TL  = wsp_pkg::TOTAL_LAT;

    logic [5:0][63:0]           r_rows;
    logic [wsp_pkg::DIM_W-1:0]  r_width;
    logic [wsp_pkg::DIM_W-1:0]  r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= '0;
            r_width  <= wsp_pkg::WIDTH_RST;
            r_height <= wsp_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (wsp_pkg::t_cfg_idx'(i_cfg_index))
                wsp_pkg::CFG_ROW_X_LO: r_rows[0] <= i_cfg_data;
                wsp_pkg::CFG_ROW_X_HI: r_rows[1] <= i_cfg_data;
                wsp_pkg::CFG_ROW_Y_LO: r_rows[2] <= i_cfg_data;
                wsp_pkg::CFG_ROW_Y_HI: r_rows[3] <= i_cfg_data;
                wsp_pkg::CFG_ROW_W_LO: r_rows[4] <= i_cfg_data;
                wsp_pkg::CFG_ROW_W_HI: r_rows[5] <= i_cfg_data;
                wsp_pkg::CFG_WIDTH:    r_width   <= i_cfg_data[wsp_pkg::DIM_W-1:0];
                wsp_pkg::CFG_HEIGHT:   r_height  <= i_cfg_data[wsp_pkg::DIM_W-1:0];
            endcase
        end
    end

    logic          en;
    logic [TL-1:0] r_vld;

    assign en            = !r_vld[TL-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[TL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TL-2:0], s_axis_tvalid};
        end
    end

    logic signed [CW-1:0] cx, cy, w;

    wsp_dot u_dot (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (s_axis_tdata[31:0]),
        .i_y    (s_axis_tdata[63:32]),
        .i_z    (s_axis_tdata[95:64]),
        .i_rows (r_rows),
        .o_cx   (cx),
        .o_cy   (cy),
        .o_w    (w)
    );

    logic signed [31:0] sx, sy;

    wsp_view #(.FLIP(1'b0)) u_view_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_c   (cx),
        .i_w   (w),
        .i_dim (r_width),
        .o_val (sx)
    );

    wsp_view #(.FLIP(1'b1)) u_view_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_c   (cy),
        .i_w   (w),
        .i_dim (r_height),
        .o_val (sy)
    );

    wsp_pkg::t_tag n_tag;
    wsp_pkg::t_tag r_tag [VL];

    always_comb begin
        n_tag.behind = w < wsp_pkg::W_NEAR;
        if (w > CW'(32'sh7FFF_FFFF)) begin
            n_tag.depth = 32'h7FFF_FFFF;
        end else if (w < -CW'(64'sh8000_0000)) begin
            n_tag.depth = 32'h8000_0000;
        end else begin
            n_tag.depth = w[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= n_tag;
            for (int i = 1; i < VL; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    assign m_axis_tuser = r_tag[VL-1].behind;
    assign m_axis_tdata = {r_tag[VL-1].depth,
                           r_tag[VL-1].behind ? 32'h0 : sy,
                           r_tag[VL-1].behind ? 32'h0 : sx};

endmodule

>>> rtl/wsp_dot.sv
module wsp_dot (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [31:0]                   i_x,
    input  logic signed [31:0]                   i_y,
    input  logic signed [31:0]                   i_z,
    input  logic [5:0][63:0]                     i_rows,
    output logic signed [wsp_pkg::CLIP_W-1:0]    o_cx,
    output logic signed [wsp_pkg::CLIP_W-1:0]    o_cy,
    output logic signed [wsp_pkg::CLIP_W-1:0]    o_w
);
    localparam int CW = wsp_pkg::CLIP_W;
    localparam int PW = wsp_pkg::PROD_W;

    logic signed [PW-1:0] r_p [9];
    logic signed [31:0]   r_t [3];
    logic signed [CW-1:0] n_s [3];
    logic signed [CW-1:0] r_s [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_p[3*r]   <= $signed(i_rows[2*r][31:0])    * i_x;
                r_p[3*r+1] <= $signed(i_rows[2*r][63:32])   * i_y;
                r_p[3*r+2] <= $signed(i_rows[2*r+1][31:0])  * i_z;
                r_t[r]     <= $signed(i_rows[2*r+1][63:32]);
            end
        end
    end

    // floor to Q16.16 is an arithmetic shift
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_s[r] = CW'(r_p[3*r] >>> 16) + CW'(r_p[3*r+1] >>> 16)
                   + CW'(r_p[3*r+2] >>> 16) + CW'(r_t[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_s[r] <= n_s[r];
            end
        end
    end

    assign o_cx = r_s[0];
    assign o_cy = r_s[1];
    assign o_w  = r_s[2];

endmodule

>>> rtl/wsp_view.sv
module wsp_view #(
    parameter bit FLIP = 1'b0
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [wsp_pkg::CLIP_W-1:0]    i_c,
    input  logic signed [wsp_pkg::CLIP_W-1:0]    i_w,
    input  logic [wsp_pkg::DIM_W-1:0]            i_dim,
    output logic signed [31:0]                   o_val
);
    localparam int CW  = wsp_pkg::CLIP_W;
    localparam int NW  = wsp_pkg::PROD_W;
    localparam int ST  = wsp_pkg::DIV_STEPS;
    localparam int FS  = wsp_pkg::FRAC_SH;
    localparam int OS  = wsp_pkg::OVF_SH;
    localparam int LW  = OS;
    localparam int HW  = NW - OS;

    // stage C: numerator sign and magnitude
    logic signed [CW:0] n_num;
    logic               r_neg_c;
    logic [CW:0]        r_mag;
    logic [CW-1:0]      r_d_c;
    logic [wsp_pkg::DIM_W-1:0] r_dim;

    assign n_num = FLIP ? ((CW+1)'(i_w) - (CW+1)'(i_c)) : ((CW+1)'(i_c) + (CW+1)'(i_w));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_c <= n_num[CW];
            r_mag   <= n_num[CW] ? (CW+1)'(-n_num) : n_num;
            r_d_c   <= i_w;
            r_dim   <= i_dim;
        end
    end

    // stage D: scale by window size
    logic [NW-1:0] r_n;
    logic          r_neg_d;
    logic [CW-1:0] r_d_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n     <= NW'(r_mag) * NW'(r_dim);
            r_neg_d <= r_neg_c;
            r_d_d   <= r_d_c;
        end
    end

    // stage E: overflow check, first partial remainder
    logic [CW-1:0] r_rem [ST+1];
    logic [ST-1:0] r_q   [ST+1];
    logic [LW-1:0] r_low [ST+1];
    logic [CW-1:0] r_d   [ST+1];
    logic          r_ovf [ST+1];
    logic          r_neg [ST+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= {{(CW-HW){1'b0}}, r_n[NW-1:OS]} >= r_d_d;
            r_rem[0] <= CW'(r_n[NW-1:OS]);
            r_low[0] <= r_n[LW-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= r_d_d;
            r_neg[0] <= r_neg_d;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < ST; k++) begin : g_div
        localparam int BI = ST - 1 - k;
        logic          n_bit;
        logic [CW:0]   n_sh;
        logic [CW:0]   n_diff;

        if (BI >= FS) begin : g_data
            assign n_bit = r_low[k][BI-FS];
        end else begin : g_zero
            assign n_bit = 1'b0;
        end

        assign n_sh   = {r_rem[k], n_bit};
        assign n_diff = n_sh - {1'b0, r_d[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_diff[CW] ? n_sh[CW-1:0] : n_diff[CW-1:0];
                r_q[k+1]   <= {r_q[k][ST-2:0], ~n_diff[CW]};
                r_low[k+1] <= r_low[k];
                r_d[k+1]   <= r_d[k];
                r_ovf[k+1] <= r_ovf[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // final: clamp and sign
    logic [ST:0]  n_m;
    logic [31:0]  n_val;
    logic [31:0]  r_val;

    always_comb begin
        n_m = r_ovf[ST] ? {1'b1, {ST{1'b0}}} : {1'b0, r_q[ST]};
        if (!r_neg[ST]) begin
            n_val = (n_m > (ST+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : n_m[31:0];
        end else begin
            n_val = (n_m >= (ST+1)'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-n_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule
